>>> rtl/tlca_pkg.sv
// tlca_pkg: sizes, types, state codes and address helper for the LCA block.
// Used by tlca_seq, tree_lca_binary_lifting_core and tlca_check; no dependencies.

package tlca_pkg;

	localparam int MAX_NODES = 1024;
	localparam int LEVELS    = 10;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ANC_DEPTH = MAX_NODES * LEVELS;
	localparam int ANC_AW    = $clog2(ANC_DEPTH);
	localparam int SPAN_W    = ((LEVELS > NODE_W) ? LEVELS : NODE_W) + 1;
	localparam int S_DATA_W  = ((2 * NODE_W + 7) / 8) * 8;
	localparam int M_DATA_W  = ((NODE_W + 7) / 8) * 8;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [LVL_W-1:0]  lvl_t;
	typedef logic [ANC_AW-1:0] anc_addr_t;

	localparam lvl_t LVL_LAST = LVL_W'(LEVELS - 1);
	localparam node_t DEPTH_MAX = NODE_W'(MAX_NODES - 1);

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_QUERY  = 1'b1
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_DEP,
		ST_INS_RD,
		ST_INS_WR,
		ST_Q_DEP,
		ST_Q_LIFT,
		ST_Q_LIFT_WR,
		ST_Q_CLIMB_RD,
		ST_Q_CLIMB_CMP,
		ST_Q_FIN_RD,
		ST_Q_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic      dep_we;
		node_t     dep_wa;
		node_t     dep_wd;
		node_t     dep_ra0;
		node_t     dep_ra1;
		logic      anc_we;
		anc_addr_t anc_wa;
		node_t     anc_wd;
		anc_addr_t anc_ra0;
		anc_addr_t anc_ra1;
	} mem_req_t;

	// read data with the sentinel node already forced to zero
	typedef struct packed {
		node_t dep0;
		node_t dep1;
		node_t anc0;
		node_t anc1;
	} mem_rd_t;

	typedef struct packed {
		node_t ancestor;
		logic  is_answer;
	} result_t;

	function automatic anc_addr_t anc_addr(node_t n, lvl_t l);
		anc_addr_t base;
		base = ANC_AW'(n) * ANC_AW'(LEVELS);
		return ANC_AW'(base + ANC_AW'(l));
	endfunction

endpackage

>>> rtl/tlca_ram.sv
// tlca_ram: generic RAM, one write port and two registered read ports.
// No package dependency; sized by its parameters.

module tlca_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd,
	input  logic [AW-1:0]    ra0,
	input  logic [AW-1:0]    ra1,
	output logic [WIDTH-1:0] rd0,
	output logic [WIDTH-1:0] rd1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd0 <= mem[ra0];
		rd1 <= mem[ra1];
	end

endmodule

>>> rtl/tlca_seq.sv
// tlca_seq: sequencer for insert and query, one table access step per state.
// Depends on tlca_pkg; drives the depth and ancestor RAMs through mem_req_t.

module tlca_seq
	import tlca_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  mode_t    in_mode,
	input  node_t    in_a,
	input  node_t    in_b,
	output mem_req_t mem_req,
	input  mem_rd_t  mem_rd,
	output logic     res_valid,
	input  logic     res_ready,
	output result_t  res
);

	state_t  state_q, state_d;
	node_t   a_q, x_q, y_q, d_q;
	lvl_t    lvl_q;
	result_t res_q;

	logic [SPAN_W-1:0] pow;
	logic              take;
	logic              swap;

	assign pow  = SPAN_W'(1) << lvl_q;
	assign take = pow <= SPAN_W'(d_q);
	assign swap = mem_rd.dep0 < mem_rd.dep1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_mode == MODE_QUERY) begin
						state_d = ST_Q_DEP;
					end else if (in_a == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_INS_DEP;
					end
				end
			end
			ST_INS_DEP:     state_d = (LEVELS == 1) ? ST_DONE : ST_INS_RD;
			ST_INS_RD:      state_d = ST_INS_WR;
			ST_INS_WR:      state_d = (lvl_q == LVL_LAST) ? ST_DONE : ST_INS_RD;
			ST_Q_DEP:       state_d = ST_Q_LIFT;
			ST_Q_LIFT: begin
				if (take) begin
					state_d = ST_Q_LIFT_WR;
				end else if (lvl_q == '0) begin
					state_d = ST_Q_CLIMB_RD;
				end
			end
			ST_Q_LIFT_WR:   state_d = (lvl_q == '0) ? ST_Q_CLIMB_RD : ST_Q_LIFT;
			ST_Q_CLIMB_RD:  state_d = ST_Q_CLIMB_CMP;
			ST_Q_CLIMB_CMP: state_d = (lvl_q == '0) ? ST_Q_FIN_RD : ST_Q_CLIMB_RD;
			ST_Q_FIN_RD:    state_d = ST_Q_FIN;
			ST_Q_FIN:       state_d = ST_DONE;
			ST_DONE:        state_d = res_ready ? ST_IDLE : ST_DONE;
			default:        state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_req   = '0;
		in_ready  = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);
		res       = res_q;
		unique case (state_q)
			ST_IDLE: begin
				mem_req.dep_ra0 = in_a;
				mem_req.dep_ra1 = in_b;
			end
			ST_INS_DEP: begin
				mem_req.dep_we = 1'b1;
				mem_req.dep_wa = a_q;
				mem_req.dep_wd = (mem_rd.dep1 >= DEPTH_MAX) ? DEPTH_MAX
					: NODE_W'(mem_rd.dep1 + 1'b1);
				mem_req.anc_we = 1'b1;
				mem_req.anc_wa = anc_addr(a_q, '0);
				mem_req.anc_wd = x_q;
			end
			ST_INS_RD: begin
				mem_req.anc_ra0 = anc_addr(x_q, LVL_W'(lvl_q - 1'b1));
			end
			ST_INS_WR: begin
				mem_req.anc_we = 1'b1;
				mem_req.anc_wa = anc_addr(a_q, lvl_q);
				mem_req.anc_wd = mem_rd.anc0;
			end
			ST_Q_LIFT: begin
				mem_req.anc_ra0 = anc_addr(x_q, lvl_q);
			end
			ST_Q_CLIMB_RD: begin
				mem_req.anc_ra0 = anc_addr(x_q, lvl_q);
				mem_req.anc_ra1 = anc_addr(y_q, lvl_q);
			end
			ST_Q_FIN_RD: begin
				mem_req.anc_ra0 = anc_addr(x_q, '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					a_q   <= in_a;
					x_q   <= (in_mode == MODE_QUERY) ? in_a : in_b;
					y_q   <= in_b;
					res_q <= '{ancestor: '0, is_answer: (in_mode == MODE_QUERY)};
				end
			end
			ST_INS_DEP: begin
				lvl_q <= LVL_W'(1);
			end
			ST_INS_WR: begin
				x_q   <= mem_rd.anc0;
				lvl_q <= LVL_W'(lvl_q + 1'b1);
			end
			ST_Q_DEP: begin
				if (swap) begin
					x_q <= y_q;
					y_q <= x_q;
					d_q <= NODE_W'(mem_rd.dep1 - mem_rd.dep0);
				end else begin
					d_q <= NODE_W'(mem_rd.dep0 - mem_rd.dep1);
				end
				lvl_q <= LVL_LAST;
			end
			ST_Q_LIFT: begin
				if (take) begin
					d_q <= NODE_W'(SPAN_W'(d_q) - pow);
				end else if (lvl_q == '0) begin
					lvl_q <= LVL_LAST;
				end else begin
					lvl_q <= LVL_W'(lvl_q - 1'b1);
				end
			end
			ST_Q_LIFT_WR: begin
				x_q   <= mem_rd.anc0;
				lvl_q <= (lvl_q == '0) ? LVL_LAST : LVL_W'(lvl_q - 1'b1);
			end
			ST_Q_CLIMB_CMP: begin
				if (mem_rd.anc0 != mem_rd.anc1) begin
					x_q <= mem_rd.anc0;
					y_q <= mem_rd.anc1;
				end
				if (lvl_q != '0) begin
					lvl_q <= LVL_W'(lvl_q - 1'b1);
				end
			end
			ST_Q_FIN: begin
				res_q.ancestor <= mem_rd.anc0;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/tree_lca_binary_lifting_core.sv
// tree_lca_binary_lifting_core: top level, RAMs, sentinel masking, output register.
// Depends on tlca_pkg, tlca_ram and tlca_seq.
//
// Usage: one request on the s_ group, one response on the m_ group.
// s_tuser selects insert (0) or query (1); s_tdata carries node_a and node_b.
// Insert adds node_a under parent node_b (0 for a root); the parent must
// already be present. Query returns the lowest common ancestor of the two
// nodes (its parent when one node is an ancestor of the other), 0 when they
// lie in separate trees. m_tuser is 1 for a query answer and 0 for an insert
// acknowledgement, whose ancestor is 0. An insert fills one ancestor level
// per read/write pair through the single write port of the ancestor RAM.
// A query runs the depth lift and then the joint climb, with a registered
// RAM read in each step; the response then passes the output register.
// s_tready is high only while the sequencer is idle; one request is worked
// on at a time.
// If m_tready is low, one finished response waits in the output register
// while the next request is taken and worked on; a second waits in the
// sequencer. Reset clears the sequencer and the output register; table
// contents are not cleared, node 0 reads as zero by address decode.

module tree_lca_binary_lifting_core
	import tlca_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // node_a, node_b, zero pad
	input  logic [0:0]          s_tuser,  // mode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // ancestor, zero pad
	output logic [0:0]          m_tuser   // is_answer
);

	mem_req_t mem_req;
	mem_rd_t  mem_rd;
	node_t    dep_rd0, dep_rd1, anc_rd0, anc_rd1;
	logic     z_dep0_q, z_dep1_q, z_anc0_q, z_anc1_q;
	logic     res_valid, res_ready;
	result_t  res;
	logic     out_valid_q;
	result_t  out_q;

	tlca_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_NODES)
	) u_dep_ram (
		.clk (clk),
		.we  (mem_req.dep_we),
		.wa  (mem_req.dep_wa),
		.wd  (mem_req.dep_wd),
		.ra0 (mem_req.dep_ra0),
		.ra1 (mem_req.dep_ra1),
		.rd0 (dep_rd0),
		.rd1 (dep_rd1)
	);

	tlca_ram #(
		.WIDTH(NODE_W),
		.DEPTH(ANC_DEPTH)
	) u_anc_ram (
		.clk (clk),
		.we  (mem_req.anc_we),
		.wa  (mem_req.anc_wa),
		.wd  (mem_req.anc_wd),
		.ra0 (mem_req.anc_ra0),
		.ra1 (mem_req.anc_ra1),
		.rd0 (anc_rd0),
		.rd1 (anc_rd1)
	);

	// node 0 row and depth are never written; mask them on read
	always_ff @(posedge clk) begin
		z_dep0_q <= (mem_req.dep_ra0 == '0);
		z_dep1_q <= (mem_req.dep_ra1 == '0);
		z_anc0_q <= (mem_req.anc_ra0 < ANC_AW'(LEVELS));
		z_anc1_q <= (mem_req.anc_ra1 < ANC_AW'(LEVELS));
	end

	assign mem_rd.dep0 = z_dep0_q ? '0 : dep_rd0;
	assign mem_rd.dep1 = z_dep1_q ? '0 : dep_rd1;
	assign mem_rd.anc0 = z_anc0_q ? '0 : anc_rd0;
	assign mem_rd.anc1 = z_anc1_q ? '0 : anc_rd1;

	tlca_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (mode_t'(s_tuser[0])),
		.in_a      (s_tdata[NODE_W-1:0]),
		.in_b      (s_tdata[2*NODE_W-1:NODE_W]),
		.mem_req   (mem_req),
		.mem_rd    (mem_rd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = M_DATA_W'(out_q.ancestor);
	assign m_tuser[0] = out_q.is_answer;

endmodule

>>> rtl/tlca_check.sv
// tlca_check: port-level assertions for tree_lca_binary_lifting_core.
// Depends on tlca_pkg; bound to the top level at the end of this file.

module tlca_check
	import tlca_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_DATA_W-1:0] s_tdata,
	input logic [0:0]          s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [0:0]          m_tuser
);

	// a stalled response stays, unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("response dropped or changed while stalled");

	// a waiting request stays unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("request changed while waiting");

	// one request at a time: busy right after a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// insert acknowledgements carry ancestor 0
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == 1'b0) |-> (m_tdata == '0))
		else $error("insert ack with nonzero ancestor");

	// a new response only appears after the sequencer was busy
	a_resp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("response without preceding work");

endmodule

bind tree_lca_binary_lifting_core tlca_check u_tlca_check (.*);
